FILE: hdl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and helpers for the first-fit heap allocator
// Heap geometry, header layout, controller commands and list helpers.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_BYTES      = 1024;
    localparam int ALIGN_BYTES     = 4;
    localparam int MIN_BLOCK_BYTES = 8;
    localparam int HEADER_BYTES    = 4;

    localparam int ADDR_W = $clog2(HEAP_BYTES);   // memory index
    localparam int PTR_W  = ADDR_W + 1;           // can hold HEAP_BYTES (end of list)
    localparam int LEN_W  = 12;                   // req_length field
    localparam int RND_W  = LEN_W + 1;            // rounded length
    localparam int BADDR_W = 10;                  // block_addr / grant_addr fields
    localparam int HW_W   = 11;                   // high_water field
    localparam int ST_W   = 2;                    // status field

    localparam logic [PTR_W-1:0] HEAP_PTR = PTR_W'(HEAP_BYTES);

    typedef logic [ST_W-1:0] status_t;
    localparam status_t ST_ALLOC = 2'd0;
    localparam status_t ST_OOM   = 2'd1;
    localparam status_t ST_FREED = 2'd2;

    typedef struct packed {
        logic [PTR_W-1:0] size;
        logic [PTR_W-1:0] nxt;
    } hdr_t;

    typedef enum logic [3:0] {
        C_NOP,
        C_INIT0,
        C_INIT1,
        C_LOAD,
        C_A_FIRST,
        C_A_STEP,
        C_A_W1,
        C_A_W2,
        C_A_W3,
        C_F_FIRST,
        C_F_STEP,
        C_F_CUR,
        C_F_W1,
        C_F_W2,
        C_RESULT
    } cmd_e_t;

    typedef struct packed {
        logic link_end;   // link just read points past the list
        logic fit;        // current block satisfies the request
        logic walk_more;  // free walk continues past the next node
        logic skip;       // free address outside the heap
        logic dup;        // address already heads a free block
    } dp_stat_t;

    // next pointer as the walk sees it: anything not strictly forward ends the list
    function automatic logic [PTR_W-1:0] link_of(input logic [PTR_W-1:0] a,
                                                 input logic [PTR_W-1:0] n);
        if (a >= HEAP_PTR || n <= a || n >= HEAP_PTR) begin
            return HEAP_PTR;
        end
        return n;
    endfunction

    function automatic logic [RND_W-1:0] round_len(input logic [LEN_W-1:0] s);
        logic [RND_W-1:0] v;
        logic [RND_W-1:0] r;
        v = (s < LEN_W'(MIN_BLOCK_BYTES)) ? RND_W'(MIN_BLOCK_BYTES) : RND_W'(s);
        r = v % RND_W'(ALIGN_BYTES);
        if (r != '0) begin
            v = v + RND_W'(ALIGN_BYTES) - r;
        end
        return v;
    endfunction

endpackage

FILE: hdl/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl: allocator sequencer
// Steps through init, list walks, header updates and result hand-off.
// ----------------------------------------------------------------------------
module ffha_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_op,
    output logic                m_tvalid,
    input  logic                m_tready,
    output ffha_pkg::status_t   m_status,
    input  ffha_pkg::dp_stat_t  stat,
    output ffha_pkg::cmd_e_t    cmd
);

    typedef enum logic [3:0] {
        S_INIT0, S_INIT1, S_IDLE,
        S_AFIRST, S_ACHK, S_AW1, S_AW2, S_AW3,
        S_FFIRST, S_FWALK, S_FCUR, S_FW1, S_FW2,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    ffha_pkg::status_t   res_reg, res_next;
    logic                mvalid_reg, mvalid_next;
    ffha_pkg::status_t   mstat_reg, mstat_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_status = mstat_reg;

    always_comb begin
        state_next  = state_reg;
        res_next    = res_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mstat_next  = mstat_reg;
        cmd         = ffha_pkg::C_NOP;
        case (state_reg)
            S_INIT0: begin
                cmd = ffha_pkg::C_INIT0;
                state_next = S_INIT1;
            end
            S_INIT1: begin
                cmd = ffha_pkg::C_INIT1;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd = ffha_pkg::C_LOAD;
                    state_next = s_op ? S_FFIRST : S_AFIRST;
                end
            end
            S_AFIRST: begin
                cmd = ffha_pkg::C_A_FIRST;
                if (stat.link_end) begin
                    res_next = ffha_pkg::ST_OOM;
                    state_next = S_DONE;
                end else begin
                    state_next = S_ACHK;
                end
            end
            S_ACHK: begin
                cmd = ffha_pkg::C_A_STEP;
                if (stat.fit) begin
                    // remainder header first; the datapath skips it on an exact fit
                    state_next = S_AW1;
                end else if (stat.link_end) begin
                    res_next = ffha_pkg::ST_OOM;
                    state_next = S_DONE;
                end
            end
            S_AW1: begin
                cmd = ffha_pkg::C_A_W1;
                state_next = S_AW2;
            end
            S_AW2: begin
                cmd = ffha_pkg::C_A_W2;
                state_next = S_AW3;
            end
            S_AW3: begin
                cmd = ffha_pkg::C_A_W3;
                res_next = ffha_pkg::ST_ALLOC;
                state_next = S_DONE;
            end
            S_FFIRST: begin
                res_next = ffha_pkg::ST_FREED;
                if (stat.skip) begin
                    state_next = S_DONE;
                end else begin
                    cmd = ffha_pkg::C_F_FIRST;
                    if (stat.walk_more) begin
                        state_next = S_FWALK;
                    end else if (!stat.link_end) begin
                        state_next = S_FCUR;
                    end else begin
                        state_next = S_FW1;
                    end
                end
            end
            S_FWALK: begin
                cmd = ffha_pkg::C_F_STEP;
                if (stat.walk_more) begin
                    state_next = S_FWALK;
                end else if (!stat.link_end) begin
                    state_next = S_FCUR;
                end else begin
                    state_next = S_FW1;
                end
            end
            S_FCUR: begin
                cmd = ffha_pkg::C_F_CUR;
                state_next = S_FW1;
            end
            S_FW1: begin
                if (stat.dup) begin
                    state_next = S_DONE;
                end else begin
                    cmd = ffha_pkg::C_F_W1;
                    state_next = S_FW2;
                end
            end
            S_FW2: begin
                cmd = ffha_pkg::C_F_W2;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    cmd = ffha_pkg::C_RESULT;
                    mvalid_next = 1'b1;
                    mstat_next = res_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_INIT0;
            res_reg    <= ffha_pkg::ST_ALLOC;
            mvalid_reg <= 1'b0;
            mstat_reg  <= ffha_pkg::ST_ALLOC;
        end else begin
            state_reg  <= state_next;
            res_reg    <= res_next;
            mvalid_reg <= mvalid_next;
            mstat_reg  <= mstat_next;
        end
    end

endmodule

FILE: hdl/ffha_dp.sv
// ----------------------------------------------------------------------------
// ffha_dp: allocator datapath
// Header memory, walk pointers, split/merge arithmetic and result registers.
// ----------------------------------------------------------------------------
module ffha_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ffha_pkg::cmd_e_t              cmd,
    output ffha_pkg::dp_stat_t            stat,
    input  logic [ffha_pkg::LEN_W-1:0]    in_len,
    input  logic [ffha_pkg::BADDR_W-1:0]  in_addr,
    output logic [ffha_pkg::BADDR_W-1:0]  out_grant,
    output logic [ffha_pkg::HW_W-1:0]     out_hw
);

    localparam int PW = ffha_pkg::PTR_W;
    localparam int AW = ffha_pkg::ADDR_W;
    localparam int RW = ffha_pkg::RND_W;
    localparam int WW = RW + 2;   // wide compare width

    ffha_pkg::hdr_t mem [ffha_pkg::HEAP_BYTES];
    ffha_pkg::hdr_t rd_reg;

    logic [RW-1:0] sz_reg;          // rounded alloc size
    logic [PW-1:0] fsz_reg;         // clamped free size
    logic [PW-1:0] baddr_reg;
    logic [PW-1:0] prev_reg, prev_size_reg, cur_reg;
    logic [PW-1:0] csz_reg, cnext_reg, nxt_reg;
    logic [PW-1:0] cur_size_reg, cur_link_reg;
    logic          exact_reg;
    logic [PW-1:0] grant_reg;
    logic [PW-1:0] peak_reg;
    logic [ffha_pkg::BADDR_W-1:0] og_reg;
    logic [ffha_pkg::HW_W-1:0]    ohw_reg;

    logic [PW-1:0] base, lnk;
    logic [WW-1:0] rsz_w, sz_w;
    logic          fit;
    logic [RW-1:0] in_rnd;
    logic [WW-1:0] in_room;
    logic [PW-1:0] in_fsz, in_baddr;
    logic          left, right;
    logic [WW-1:0] esize, estart;
    logic [PW-1:0] rem, alloc_end;
    logic [PW-1:0] merged_tail;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    ffha_pkg::hdr_t wdata;

    assign base = (cmd == ffha_pkg::C_A_FIRST || cmd == ffha_pkg::C_F_FIRST) ? '0 : cur_reg;
    assign lnk  = ffha_pkg::link_of(base, rd_reg.nxt);

    assign rsz_w = WW'(rd_reg.size);
    assign sz_w  = WW'(sz_reg);
    assign fit   = (rsz_w == sz_w) ||
                   ((sz_w + WW'(ffha_pkg::MIN_BLOCK_BYTES) <= rsz_w) &&
                    (WW'(cur_reg) + sz_w < WW'(ffha_pkg::HEAP_BYTES)));

    assign stat.link_end  = (lnk >= ffha_pkg::HEAP_PTR);
    assign stat.fit       = fit;
    assign stat.walk_more = (lnk < ffha_pkg::HEAP_PTR) && (lnk <= baddr_reg);
    assign stat.skip      = (baddr_reg == '0) || (baddr_reg >= ffha_pkg::HEAP_PTR);
    assign stat.dup       = (prev_reg == baddr_reg);

    // free size: rounded, then clamped to the heap end
    assign in_baddr = PW'(in_addr);
    assign in_rnd   = ffha_pkg::round_len(in_len);
    assign in_room  = WW'(ffha_pkg::HEAP_BYTES) - WW'(in_baddr);
    assign in_fsz   = (WW'(in_rnd) > in_room) ? PW'(in_room) : PW'(in_rnd);

    // merge decisions
    assign left   = (WW'(prev_reg) + WW'(prev_size_reg)) == WW'(baddr_reg);
    assign estart = left ? WW'(prev_reg) : WW'(baddr_reg);
    assign esize  = left ? WW'(prev_size_reg) + WW'(fsz_reg) : WW'(fsz_reg);
    assign right  = (cur_reg < ffha_pkg::HEAP_PTR) && (estart + esize == WW'(cur_reg));
    assign merged_tail = right ? cur_link_reg : cur_reg;

    assign rem       = PW'(WW'(cur_reg) + sz_w);
    assign alloc_end = rem;

    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = lnk[AW-1:0];
        case (cmd)
            ffha_pkg::C_INIT0: begin
                we = 1'b1;
                waddr = '0;
                wdata.size = '0;
                wdata.nxt = PW'(ffha_pkg::HEADER_BYTES);
            end
            ffha_pkg::C_INIT1: begin
                we = 1'b1;
                waddr = AW'(ffha_pkg::HEADER_BYTES);
                wdata.size = PW'(ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES);
                wdata.nxt = ffha_pkg::HEAP_PTR;
            end
            ffha_pkg::C_LOAD: begin
                raddr = '0;
            end
            ffha_pkg::C_A_W1: begin
                // exact fit: no remainder, block only unlinks
                we = !exact_reg;
                waddr = rem[AW-1:0];
                wdata.size = csz_reg - PW'(sz_reg);
                wdata.nxt = nxt_reg;
            end
            ffha_pkg::C_A_W2: begin
                we = !exact_reg;
                waddr = cur_reg[AW-1:0];
                wdata.size = PW'(sz_reg);
                wdata.nxt = cnext_reg;
            end
            ffha_pkg::C_A_W3: begin
                we = 1'b1;
                waddr = prev_reg[AW-1:0];
                wdata.size = prev_size_reg;
                wdata.nxt = exact_reg ? nxt_reg : rem;
            end
            ffha_pkg::C_F_W1: begin
                we = 1'b1;
                waddr = baddr_reg[AW-1:0];
                if (left) begin
                    wdata.size = fsz_reg;
                    wdata.nxt = cur_reg;
                end else begin
                    wdata.size = fsz_reg + (right ? cur_size_reg : '0);
                    wdata.nxt = merged_tail;
                end
            end
            ffha_pkg::C_F_W2: begin
                we = 1'b1;
                waddr = prev_reg[AW-1:0];
                if (left) begin
                    wdata.size = prev_size_reg + fsz_reg + (right ? cur_size_reg : '0);
                    wdata.nxt = merged_tail;
                end else begin
                    wdata.size = prev_size_reg;
                    wdata.nxt = baddr_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // header memory, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        case (cmd)
            ffha_pkg::C_LOAD: begin
                sz_reg    <= in_rnd;
                fsz_reg   <= in_fsz;
                baddr_reg <= in_baddr;
                grant_reg <= '0;
                exact_reg <= 1'b0;
            end
            ffha_pkg::C_A_FIRST, ffha_pkg::C_F_FIRST: begin
                prev_reg      <= '0;
                prev_size_reg <= rd_reg.size;
                cur_reg       <= lnk;
            end
            ffha_pkg::C_F_STEP: begin
                prev_reg      <= cur_reg;
                prev_size_reg <= rd_reg.size;
                cur_reg       <= lnk;
            end
            ffha_pkg::C_A_STEP: begin
                if (fit) begin
                    csz_reg   <= rd_reg.size;
                    cnext_reg <= rd_reg.nxt;
                    nxt_reg   <= lnk;
                    exact_reg <= (rsz_w == sz_w);
                end else begin
                    prev_reg      <= cur_reg;
                    prev_size_reg <= rd_reg.size;
                    cur_reg       <= lnk;
                end
            end
            ffha_pkg::C_F_CUR: begin
                cur_size_reg <= rd_reg.size;
                cur_link_reg <= lnk;
            end
            ffha_pkg::C_A_W3: begin
                grant_reg <= cur_reg;
            end
            ffha_pkg::C_RESULT: begin
                og_reg  <= ffha_pkg::BADDR_W'(grant_reg);
                ohw_reg <= ffha_pkg::HW_W'(peak_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg <= '0;
        end else if (cmd == ffha_pkg::C_A_W3 && alloc_end > peak_reg) begin
            peak_reg <= alloc_end;
        end
    end

    assign out_grant = og_reg;
    assign out_hw    = ohw_reg;

endmodule

FILE: hdl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit allocator over a 1 KiB heap
// Address-ordered free list with split on allocate and coalesce on free.
// ----------------------------------------------------------------------------
// Usage: one request per slave handshake, s_tuser[0] = opcode (0 allocate,
//   1 free). Exactly one result per request, in order; m_tuser = status
//   (0 allocated, 1 out of memory, 2 freed).
// Throughput: one request at a time, one header read per cycle
//   from a header RAM with registered read. An allocate walks the free
//   list until a block fits or the list ends; a free walks the free blocks
//   at or below block_addr, and skips the walk for an address outside the
//   heap. s_tready rises with m_tvalid, so the next request is taken only
//   once the previous result has been registered.
// Reset: aresetn low clears control state and the usage peak; the sequencer
//   then writes the sentinel and the whole-heap block, s_tready stays low.
// Stall: a result waits in the output register. The next request is still
//   accepted and processed; its result holds until the previous one is taken.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [11:0] req_length, [21:12] block_addr, [23:22] zero
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [9:0] grant_addr, [20:10] high_water, [23:21] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    ffha_pkg::cmd_e_t   cmd;
    ffha_pkg::dp_stat_t stat;
    ffha_pkg::status_t  status;
    logic [ffha_pkg::BADDR_W-1:0] grant;
    logic [ffha_pkg::HW_W-1:0]    hw;

    ffha_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_status (status),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffha_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_len    (s_tdata[11:0]),
        .in_addr   (s_tdata[21:12]),
        .out_grant (grant),
        .out_hw    (hw)
    );

    assign m_tdata = {3'b000, hw, grant};
    assign m_tuser = status;

endmodule

FILE: hdl/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_assertions: port-level checks for the heap allocator
// Result channel behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module ffha_assertions (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ffha_pkg::ST_ALLOC || m_tuser == ffha_pkg::ST_OOM ||
                      m_tuser == ffha_pkg::ST_FREED))
        else $error("bad status code");

    a_nogrant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ffha_pkg::ST_ALLOC |-> m_tdata[9:0] == 10'd0)
        else $error("address given without a grant");

    a_hw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[20:10] <= 11'(ffha_pkg::HEAP_BYTES))
        else $error("high water beyond heap");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("channel active right after reset");

endmodule

bind first_fit_heap_allocator ffha_assertions u_ffha_assertions (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: bench/ffha_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffha_checker: result predictor and scoreboard for the heap allocator
// Keeps a private free list, predicts one result per accepted request and
// compares it with the results taken on the master channel.
// ----------------------------------------------------------------------------
module ffha_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic [ffha_pkg::BADDR_W-1:0] grant;
        ffha_pkg::status_t            status;
        logic [ffha_pkg::HW_W-1:0]    peak;
    } alloc_result_t;

    int blk_size [ffha_pkg::HEAP_BYTES];
    int blk_next [ffha_pkg::HEAP_BYTES];
    int peak_end;
    alloc_result_t due_q[$];

    // forward-only link; anything else ends the walk
    function automatic int fwd_link(int a);
        int n;
        if (a >= ffha_pkg::HEAP_BYTES) return ffha_pkg::HEAP_BYTES;
        n = blk_next[a];
        if (n <= a || n >= ffha_pkg::HEAP_BYTES) return ffha_pkg::HEAP_BYTES;
        return n;
    endfunction

    function automatic int rounded(int s);
        int v;
        v = (s < ffha_pkg::MIN_BLOCK_BYTES) ? ffha_pkg::MIN_BLOCK_BYTES : s;
        if (v % ffha_pkg::ALIGN_BYTES != 0)
            v += ffha_pkg::ALIGN_BYTES - v % ffha_pkg::ALIGN_BYTES;
        return v;
    endfunction

    function automatic int grant_block(int len);
        int want, prev, cur, csz, nxt, rem;
        want = rounded(len);
        prev = 0;
        forever begin
            cur = fwd_link(prev);
            if (cur >= ffha_pkg::HEAP_BYTES) return -1;
            csz = blk_size[cur];
            if (csz == want) break;
            if (want + ffha_pkg::MIN_BLOCK_BYTES <= csz &&
                cur + want < ffha_pkg::HEAP_BYTES) break;
            prev = cur;
        end
        nxt = fwd_link(cur);
        if (csz == want) begin
            blk_next[prev] = nxt;
        end else begin
            rem = cur + want;
            blk_size[rem] = csz - want;
            blk_next[rem] = nxt;
            blk_size[cur] = want;
            blk_next[prev] = rem;
        end
        if (cur + want > peak_end) peak_end = cur + want;
        return cur;
    endfunction

    function automatic void release_block(int addr, int len);
        int sz, prev, cur, e;
        if (addr == 0 || addr >= ffha_pkg::HEAP_BYTES) return;
        sz = rounded(len);
        if (sz > ffha_pkg::HEAP_BYTES - addr) sz = ffha_pkg::HEAP_BYTES - addr;
        prev = 0;
        cur = fwd_link(0);
        while (cur < ffha_pkg::HEAP_BYTES && cur <= addr) begin
            prev = cur;
            cur = fwd_link(cur);
        end
        if (prev == addr) return;   // already heads a free block
        blk_size[addr] = sz;
        blk_next[addr] = cur;
        blk_next[prev] = addr;
        e = addr;
        if (prev + blk_size[prev] == addr) begin
            blk_size[prev] += sz;
            blk_next[prev] = cur;
            e = prev;
        end
        if (cur < ffha_pkg::HEAP_BYTES && e + blk_size[e] == cur) begin
            blk_size[e] += blk_size[cur];
            blk_next[e] = fwd_link(cur);
        end
    endfunction

    always @(posedge aclk) begin
        alloc_result_t exp_r;
        int g;
        if (!aresetn) begin
            foreach (blk_size[i]) begin
                blk_size[i] = 0;
                blk_next[i] = 0;
            end
            blk_next[0] = ffha_pkg::HEADER_BYTES;
            blk_size[ffha_pkg::HEADER_BYTES] = ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES;
            blk_next[ffha_pkg::HEADER_BYTES] = ffha_pkg::HEAP_BYTES;
            peak_end = 0;
            fail_count <= 0;
            due_q.delete();
            pending <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == 1'b0) begin
                    g = grant_block(int'(s_tdata[11:0]));
                    exp_r.grant  = (g < 0) ? '0 : ffha_pkg::BADDR_W'(g);
                    exp_r.status = (g < 0) ? ffha_pkg::ST_OOM : ffha_pkg::ST_ALLOC;
                end else begin
                    release_block(int'(s_tdata[21:12]), int'(s_tdata[11:0]));
                    exp_r.grant  = '0;
                    exp_r.status = ffha_pkg::ST_FREED;
                end
                exp_r.peak = (peak_end > 2047) ? 11'd2047 : ffha_pkg::HW_W'(peak_end);
                due_q.push_back(exp_r);
            end
            if (m_tvalid && m_tready) begin
                if (due_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("ERROR: result with no request outstanding: %h/%0d",
                                 m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = due_q.pop_front();
                    if (m_tdata[9:0] !== exp_r.grant || m_tuser !== exp_r.status ||
                        m_tdata[20:10] !== exp_r.peak || m_tdata[23:21] !== 3'b0) begin
                        if (fail_count < 10)
                            $display("ERROR: grant %0d/%0d status %0d/%0d peak %0d/%0d",
                                     exp_r.grant, m_tdata[9:0], exp_r.status, m_tuser,
                                     exp_r.peak, m_tdata[20:10]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= due_q.size();
        end
    end

endmodule

FILE: bench/first_fit_heap_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb: stimulus and verdict for the heap allocator
// Directed corner requests, then mostly well-formed alloc/free traffic with
// some noise, random idles on both channels; ffha_checker does the checking.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb;

    localparam int RANDOM_REQS = 1500;
    localparam int WDOG_LIMIT  = 20000;   // cycles with no handshake at all

    typedef struct {
        int addr;
        int len;
    } live_blk_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    int fail_count;
    int pending;
    int idle_cnt = 0;
    bit quiet = 1'b0;             // no-idle stretch on both channels

    live_blk_t live_q[$];         // granted blocks not yet freed
    int alloc_len_q[$];           // length per outstanding request, -1 for free
    int freed_addr;

    always #5 aclk = ~aclk;

    first_fit_heap_allocator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    ffha_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 6);
    end

    // learn granted addresses so frees can target real blocks
    always @(posedge aclk) begin
        int len;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                alloc_len_q.push_back(s_tuser[0] ? -1 : int'(s_tdata[11:0]));
            if (m_tvalid && m_tready && alloc_len_q.size() > 0) begin
                len = alloc_len_q.pop_front();
                if (m_tuser == ffha_pkg::ST_ALLOC)
                    live_q.push_back('{addr: int'(m_tdata[9:0]), len: len});
            end
        end
    end

    // watchdog: no handshake on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WDOG_LIMIT) begin
                $display("first_fit_heap_allocator test failed");
                $finish;
            end
        end
    end

    task automatic send_req(input bit op, input int len, input int addr);
        while (!quiet && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, 10'(addr), 12'(len)};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic alloc_req(input int len);
        send_req(1'b0, len, $urandom_range(1023));   // address is don't-care
    endtask

    task automatic free_live(input bit keep_len);
        int idx;
        live_blk_t b;
        if (live_q.size() == 0) return;
        idx = $urandom_range(live_q.size() - 1);
        b = live_q[idx];
        live_q.delete(idx);
        freed_addr = b.addr;
        send_req(1'b1, keep_len ? b.len : $urandom_range(64), b.addr);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int r;
        int n;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners
        alloc_req(0);                 // rounded up to minimum block
        alloc_req(4095);              // far too large: out of memory
        alloc_req(1);
        alloc_req(9);                 // alignment rounding
        alloc_req(7);
        send_req(1'b1, 16, 0);        // sentinel address: ignored
        wait_drained();
        free_live(1'b1);
        send_req(1'b1, 8, freed_addr);    // double free
        send_req(1'b1, 4095, 1023);       // length clamped at heap end
        send_req(1'b1, 4095, 1023);
        alloc_req(4);
        wait_drained();
        while (live_q.size() > 0) free_live(1'b1);   // coalesce back to one block
        wait_drained();
        alloc_req(ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES);   // whole heap
        alloc_req(8);                                // nothing left
        wait_drained();
        free_live(1'b1);
        alloc_req(ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES - 4);   // remainder too small to split: out of memory
        alloc_req(3000);
        wait_drained();

        // random traffic
        for (n = 0; n < RANDOM_REQS; n++) begin
            quiet = (n >= 500 && n < 800);
            if (n == 1000) wait_drained();           // hold off until drained
            if (!quiet && $urandom_range(99) < 2) wait_drained();
            r = $urandom_range(99);
            if (r < 5) begin
                send_req(1'b1, $urandom_range(4095), $urandom_range(1023));   // noise
            end else if (r < 8 && freed_addr > 0) begin
                send_req(1'b1, $urandom_range(32), freed_addr);   // repeat free
            end else if (live_q.size() > 0 &&
                         $urandom_range(99) < 30 + live_q.size() * 2) begin
                free_live($urandom_range(9) != 0);
            end else if (r < 12) begin
                alloc_req($urandom_range(4095));
            end else begin
                alloc_req($urandom_range(1, 64));
            end
        end
        quiet = 1'b0;
        wait_drained();
        repeat (50) @(posedge aclk);
        if (fail_count == 0) begin
            $display("first_fit_heap_allocator test passed");
        end else begin
            $display("first_fit_heap_allocator test failed");
        end
        $finish;
    end

endmodule

FILE: first_fit_heap_allocator.f
hdl/ffha_pkg.sv
hdl/ffha_ctrl.sv
hdl/ffha_dp.sv
hdl/first_fit_heap_allocator.sv
hdl/ffha_checker.sv
bench/ffha_checker.sv
bench/first_fit_heap_allocator_tb.sv
